// ===== sv/atrw_pkg.sv =====
package atrw_pkg;

    localparam int MAX_WINDOW  = 64;
    localparam int PRICE_BITS  = 32;

    localparam int PERIOD_BITS = 7;
    localparam int MINBAR_BITS = 12;
    localparam int BARS_BITS   = 12;
    localparam int CFG_BITS    = 12;
    localparam int CFG_INDEX_BITS = 1;

    localparam int IDX_BITS  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int K_BITS    = $clog2(MAX_WINDOW + 1);
    localparam int SUM_BITS  = PRICE_BITS + $clog2(MAX_WINDOW);
    localparam int DCNT_BITS = $clog2(SUM_BITS + 1);

    localparam logic [BARS_BITS-1:0] BARS_MAX = {BARS_BITS{1'b1}};

    localparam logic [CFG_INDEX_BITS-1:0] CFG_WINDOW_PERIOD = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MINIMUM_BARS  = 1'b1;

    localparam logic [PERIOD_BITS-1:0] WINDOW_PERIOD_RESET = 7'd14;
    localparam logic [MINBAR_BITS-1:0] MINIMUM_BARS_RESET  = 12'd15;

    typedef struct packed {
        logic [PRICE_BITS-1:0] high_value;
        logic [PRICE_BITS-1:0] low_value;
        logic [PRICE_BITS-1:0] close_value;
        logic                  start_series;
    } bar_t;

    typedef struct packed {
        logic [PRICE_BITS-1:0] average_range;
        logic                  range_valid;
    } result_t;

endpackage

// ===== sv/average_true_range_window.sv =====
// A bar passes through range, sum (serial ring read of the k averaged ranges,
// k = min(window_period capped at 64, bars - 1)) and a bit-serial divide; an invalid result skips both.
// A new bar is taken only in idle, once the last result has moved to the output register;
// result_stall holding that register delays this.
// Reset (rst_n, async, low) clears history, bar count and output valid, and loads
// window_period = 14, minimum_bars = 15. The range ring is not cleared.
module average_true_range_window (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [atrw_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [atrw_pkg::CFG_BITS-1:0]         cfg_data,
    input  logic                                  bar_valid,
    output logic                                  bar_stall,
    input  atrw_pkg::bar_t                        bar,
    output logic                                  result_valid,
    input  logic                                  result_stall,
    output atrw_pkg::result_t                     result
);

    localparam int PB = atrw_pkg::PRICE_BITS;
    localparam int IB = atrw_pkg::IDX_BITS;
    localparam int KB = atrw_pkg::K_BITS;
    localparam int SB = atrw_pkg::SUM_BITS;
    localparam int DB = atrw_pkg::DCNT_BITS;
    localparam int BB = atrw_pkg::BARS_BITS;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RANGE,
        ST_SUM,
        ST_DIVIDE,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;

    logic [atrw_pkg::PERIOD_BITS-1:0] window_period_reg, window_period_next;
    logic [atrw_pkg::MINBAR_BITS-1:0] minimum_bars_reg, minimum_bars_next;

    logic [PB-1:0] prev_close_reg, prev_close_next;
    logic [BB-1:0] bars_reg, bars_next;
    logic [IB-1:0] pos_reg, pos_next;
    logic [IB-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PB-1:0] span_reg, span_next;
    logic [PB-1:0] up_reg, up_next;
    logic [PB-1:0] down_reg, down_next;
    logic          tr_en_reg, tr_en_next;
    logic [KB-1:0] k_reg, k_next;
    logic [KB-1:0] issued_reg, issued_next;
    logic          rd_pend_reg, rd_pend_next;
    logic [SB-1:0] acc_reg, acc_next;
    logic [SB-1:0] div_reg, div_next;
    logic [KB-1:0] rem_reg, rem_next;
    logic [PB-1:0] quo_reg, quo_next;
    logic [DB-1:0] dcnt_reg, dcnt_next;
    atrw_pkg::result_t res_reg, res_next;
    atrw_pkg::result_t out_reg, out_next;
    logic          out_valid_reg, out_valid_next;

    logic [PB-1:0] ring [atrw_pkg::MAX_WINDOW];
    logic [PB-1:0] rd_data_reg;

    logic          accept;
    logic          ring_we;
    logic [PB-1:0] tr_value;
    logic [PB-1:0] tr_hl;
    logic [BB-1:0] bars_base;
    logic [BB-1:0] bars_m1;
    logic [KB-1:0] period_eff;
    logic          avg_ok;
    logic [KB:0]   trial;
    logic          q_bit;

    assign bar_stall    = (state_reg != ST_IDLE);
    assign accept       = bar_valid && !bar_stall;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_comb
    begin
        tr_hl    = (span_reg > up_reg) ? span_reg : up_reg;
        tr_value = (down_reg > tr_hl) ? down_reg : tr_hl;
        ring_we  = (state_reg == ST_RANGE) && tr_en_reg;

        bars_base = bar.start_series ? '0 : bars_reg;
        bars_m1   = bars_reg - BB'(1);
        if (32'(window_period_reg) > 32'(atrw_pkg::MAX_WINDOW))
        begin
            period_eff = KB'(atrw_pkg::MAX_WINDOW);
        end
        else
        begin
            period_eff = KB'(window_period_reg);
        end
        avg_ok = tr_en_reg && (bars_reg >= minimum_bars_reg) && (period_eff != '0);

        trial = {rem_reg, div_reg[SB-1]};
        q_bit = (trial >= {1'b0, k_reg});

        state_next         = state_reg;
        window_period_next = window_period_reg;
        minimum_bars_next  = minimum_bars_reg;
        prev_close_next    = prev_close_reg;
        bars_next          = bars_reg;
        pos_next           = pos_reg;
        rd_ptr_next        = rd_ptr_reg;
        span_next          = span_reg;
        up_next            = up_reg;
        down_next          = down_reg;
        tr_en_next         = tr_en_reg;
        k_next             = k_reg;
        issued_next        = issued_reg;
        rd_pend_next       = 1'b0;
        acc_next           = acc_reg;
        div_next           = div_reg;
        rem_next           = rem_reg;
        quo_next           = quo_reg;
        dcnt_next          = dcnt_reg;
        res_next           = res_reg;
        out_next           = out_reg;
        out_valid_next     = out_valid_reg && result_stall;

        if (cfg_write)
        begin
            unique case (cfg_index)
                atrw_pkg::CFG_WINDOW_PERIOD:
                    window_period_next = cfg_data[atrw_pkg::PERIOD_BITS-1:0];
                atrw_pkg::CFG_MINIMUM_BARS:
                    minimum_bars_next = cfg_data[atrw_pkg::MINBAR_BITS-1:0];
                default:
                    ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    bars_next = (bars_base == atrw_pkg::BARS_MAX) ?
                                bars_base : bars_base + BB'(1);
                    if (bar.start_series)
                    begin
                        pos_next = '0;
                    end
                    tr_en_next = (bars_next >= BB'(2));
                    span_next  = (bar.high_value >= bar.low_value) ?
                                 bar.high_value - bar.low_value : '0;
                    up_next    = (bar.high_value >= prev_close_reg) ?
                                 bar.high_value - prev_close_reg :
                                 prev_close_reg - bar.high_value;
                    down_next  = (bar.low_value >= prev_close_reg) ?
                                 bar.low_value - prev_close_reg :
                                 prev_close_reg - bar.low_value;
                    prev_close_next = bar.close_value;
                    state_next      = ST_RANGE;
                end
            end
            ST_RANGE:
            begin
                if (tr_en_reg)
                begin
                    pos_next    = (32'(pos_reg) == atrw_pkg::MAX_WINDOW - 1) ?
                                  '0 : pos_reg + IB'(1);
                    rd_ptr_next = pos_reg;
                end
                if (32'(bars_m1) > 32'(period_eff))
                begin
                    k_next = period_eff;
                end
                else
                begin
                    k_next = KB'(bars_m1);
                end
                issued_next = '0;
                acc_next    = '0;
                if (avg_ok)
                begin
                    state_next = ST_SUM;
                end
                else
                begin
                    res_next   = '0;
                    state_next = ST_DONE;
                end
            end
            ST_SUM:
            begin
                if (issued_reg < k_reg)
                begin
                    rd_pend_next = 1'b1;
                    issued_next  = issued_reg + KB'(1);
                    rd_ptr_next  = (rd_ptr_reg == '0) ?
                                   IB'(atrw_pkg::MAX_WINDOW - 1) : rd_ptr_reg - IB'(1);
                end
                if (rd_pend_reg)
                begin
                    acc_next = acc_reg + SB'(rd_data_reg);
                end
                if ((issued_reg == k_reg) && !rd_pend_reg)
                begin
                    div_next   = acc_reg;
                    rem_next   = '0;
                    quo_next   = '0;
                    dcnt_next  = '0;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                rem_next  = q_bit ? KB'(trial - {1'b0, k_reg}) : KB'(trial);
                quo_next  = {quo_reg[PB-2:0], q_bit};
                div_next  = {div_reg[SB-2:0], 1'b0};
                dcnt_next = dcnt_reg + DB'(1);
                if (dcnt_reg == DB'(SB - 1))
                begin
                    res_next.average_range = quo_next;
                    res_next.range_valid   = 1'b1;
                    state_next             = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            window_period_reg <= atrw_pkg::WINDOW_PERIOD_RESET;
            minimum_bars_reg  <= atrw_pkg::MINIMUM_BARS_RESET;
            prev_close_reg    <= '0;
            bars_reg          <= '0;
            pos_reg           <= '0;
            rd_ptr_reg        <= '0;
            span_reg          <= '0;
            up_reg            <= '0;
            down_reg          <= '0;
            tr_en_reg         <= 1'b0;
            k_reg             <= '0;
            issued_reg        <= '0;
            rd_pend_reg       <= 1'b0;
            acc_reg           <= '0;
            div_reg           <= '0;
            rem_reg           <= '0;
            quo_reg           <= '0;
            dcnt_reg          <= '0;
            res_reg           <= '0;
            out_reg           <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            window_period_reg <= window_period_next;
            minimum_bars_reg  <= minimum_bars_next;
            prev_close_reg    <= prev_close_next;
            bars_reg          <= bars_next;
            pos_reg           <= pos_next;
            rd_ptr_reg        <= rd_ptr_next;
            span_reg          <= span_next;
            up_reg            <= up_next;
            down_reg          <= down_next;
            tr_en_reg         <= tr_en_next;
            k_reg             <= k_next;
            issued_reg        <= issued_next;
            rd_pend_reg       <= rd_pend_next;
            acc_reg           <= acc_next;
            div_reg           <= div_next;
            rem_reg           <= rem_next;
            quo_reg           <= quo_next;
            dcnt_reg          <= dcnt_next;
            res_reg           <= res_next;
            out_reg           <= out_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // range ring: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring[pos_reg] <= tr_value;
        end
        rd_data_reg <= ring[rd_ptr_reg];
    end

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVIDE) |-> ({1'b0, rem_reg} < {1'b0, k_reg}))
        else $error("divide remainder not below window count");

    a_issue_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SUM) |-> (issued_reg <= k_reg) && (k_reg != '0))
        else $error("ring reads exceed window count");

    a_invalid_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.range_valid) |-> (result.average_range == '0))
        else $error("invalid result carries nonzero average");

    a_taken_drops: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_stall && (state_reg != ST_DONE)) |=> !result_valid)
        else $error("result repeated after transaction");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int PB = atrw_pkg::PRICE_BITS;
    localparam int CB = atrw_pkg::CFG_BITS;

    typedef enum int {STALL_NONE, STALL_RANDOM, STALL_RUNS} stall_style_t;

    class atr_checker_t;
        logic [atrw_pkg::PERIOD_BITS-1:0] period;
        logic [atrw_pkg::MINBAR_BITS-1:0] min_bars;
        logic [PB-1:0]                    last_close;
        logic [PB-1:0]                    ranges [atrw_pkg::MAX_WINDOW];
        logic [atrw_pkg::IDX_BITS-1:0]    next_slot;
        logic [atrw_pkg::BARS_BITS-1:0]   bar_count;
        atrw_pkg::result_t                pending_averages [$];
        int                               errors;

        function new();
            period     = atrw_pkg::WINDOW_PERIOD_RESET;
            min_bars   = atrw_pkg::MINIMUM_BARS_RESET;
            last_close = '0;
            next_slot  = '0;
            bar_count  = '0;
            errors     = 0;
        endfunction

        function void set_window(logic [CB-1:0] period_data,
                                 logic [CB-1:0] min_data);
            period   = period_data[atrw_pkg::PERIOD_BITS-1:0];
            min_bars = min_data[atrw_pkg::MINBAR_BITS-1:0];
        endfunction

        function void note_bar(atrw_pkg::bar_t b);
            logic [PB-1:0]                 tr;
            logic [PB-1:0]                 d_high;
            logic [PB-1:0]                 d_low;
            logic [atrw_pkg::SUM_BITS-1:0] total;
            int                            eff_period;
            int                            span;
            atrw_pkg::result_t             r;

            if (b.start_series)
            begin
                bar_count = '0;
                next_slot = '0;
            end
            if (bar_count != atrw_pkg::BARS_MAX)
                bar_count++;

            if (bar_count >= 2)
            begin
                tr = (b.high_value >= b.low_value) ? b.high_value - b.low_value : '0;
                d_high = (b.high_value >= last_close) ? b.high_value - last_close
                                                      : last_close - b.high_value;
                d_low  = (b.low_value >= last_close) ? b.low_value - last_close
                                                     : last_close - b.low_value;
                if (d_high > tr)
                    tr = d_high;
                if (d_low > tr)
                    tr = d_low;
                ranges[next_slot] = tr;
                next_slot++;
            end
            last_close = b.close_value;

            eff_period = (int'(period) > atrw_pkg::MAX_WINDOW) ? atrw_pkg::MAX_WINDOW
                                                               : int'(period);
            r = '0;
            if (bar_count >= 2 && bar_count >= min_bars && eff_period >= 1)
            begin
                span = int'(bar_count) - 1;
                if (span > eff_period)
                    span = eff_period;
                total = '0;
                for (int i = 1; i <= span; i++)
                    total += ranges[atrw_pkg::IDX_BITS'(int'(next_slot) - i)];
                r.average_range = PB'(total / span);
                r.range_valid   = 1'b1;
            end
            pending_averages = {pending_averages, r};
        endfunction

        task report(string msg);
            if (errors < 100)
                $display("%0t mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task check_average(atrw_pkg::result_t got);
            atrw_pkg::result_t want;

            if (pending_averages.size() == 0)
            begin
                report("result transaction with no bar pending");
                return;
            end
            want = pending_averages.pop_front();
            if (got.average_range !== want.average_range)
                report($sformatf("average_range got %h want %h",
                                 got.average_range, want.average_range));
            if (got.range_valid !== want.range_valid)
                report($sformatf("range_valid got %b want %b",
                                 got.range_valid, want.range_valid));
        endtask
    endclass

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                cfg_write = 1'b0;
    logic [atrw_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CB-1:0]                       cfg_data = '0;
    logic                                bar_valid = 1'b0;
    logic                                bar_stall;
    atrw_pkg::bar_t                      bar = '0;
    logic                                result_valid;
    logic                                result_stall = 1'b0;
    atrw_pkg::result_t                   result;

    atr_checker_t          board = new();
    int                    cycle_count = 0;
    int                    burst_left = 0;
    bit                    sender_gaps = 1'b1;
    logic [PB-1:0]         walk_price = 32'd1_000_000;
    stall_style_t          stall_style = STALL_NONE;
    int                    stall_run = 0;
    int                    stall_tick = 0;

    average_true_range_window dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .bar_valid    (bar_valid),
        .bar_stall    (bar_stall),
        .bar          (bar),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("RESULT: ERROR");
        $finish;
    end

    // result side: check accepted transactions, stall in changing styles
    always @(posedge clk)
    begin
        if (result_valid && !result_stall)
            board.check_average(result);
        stall_tick++;
        if (stall_tick % 200 == 0)
            stall_style = stall_style_t'($urandom_range(0, 2));
        case (stall_style)
            STALL_NONE:   result_stall <= 1'b0;
            STALL_RANDOM: result_stall <= ($urandom_range(0, 2) == 0);
            default:
            begin
                if (stall_run == 0 && $urandom_range(0, 7) == 0)
                    stall_run = $urandom_range(1, 20);
                result_stall <= (stall_run != 0);
                if (stall_run != 0)
                    stall_run--;
            end
        endcase
    end

    function automatic atrw_pkg::bar_t make_bar(logic [PB-1:0] high_p,
                                                logic [PB-1:0] low_p,
                                                logic [PB-1:0] close_p,
                                                logic start);
        atrw_pkg::bar_t b;

        b.high_value   = high_p;
        b.low_value    = low_p;
        b.close_value  = close_p;
        b.start_series = start;
        return b;
    endfunction

    function automatic logic [PB-1:0] extreme_price();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            2:       return 32'h8000_0000;
            default: return 32'd1;
        endcase
    endfunction

    function automatic atrw_pkg::bar_t random_bar(logic start);
        atrw_pkg::bar_t b;
        logic [PB-1:0]  spread;

        case ($urandom_range(0, 9))
            0, 1:
            begin
                b.high_value  = $urandom;
                b.low_value   = $urandom;
                b.close_value = $urandom;
            end
            2:
            begin
                b.high_value  = extreme_price();
                b.low_value   = extreme_price();
                b.close_value = extreme_price();
            end
            default:
            begin
                walk_price    = walk_price + $urandom_range(0, 4000) - 2000;
                spread        = $urandom_range(0, 3000);
                b.high_value  = walk_price + spread;
                b.low_value   = walk_price - spread;
                b.close_value = b.low_value + $urandom_range(0, 2 * spread);
            end
        endcase
        b.start_series = start;
        return b;
    endfunction

    // called at a rising edge; returns at the edge that accepted the transaction
    task automatic send_bar(input atrw_pkg::bar_t b);
        int gap;

        if (burst_left == 0)
        begin
            gap = sender_gaps ? $urandom_range(0, 8) : 0;
            if (gap > 0)
            begin
                bar_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        bar       <= b;
        bar_valid <= 1'b1;
        do
            @(posedge clk);
        while (bar_stall);
        board.note_bar(b);
    endtask

    task automatic finish_phase();
        bar_valid <= 1'b0;
        burst_left = 0;
        while (board.pending_averages.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_window(input logic [CB-1:0] period_data,
                              input logic [CB-1:0] min_data);
        cfg_write <= 1'b1;
        cfg_index <= atrw_pkg::CFG_WINDOW_PERIOD;
        cfg_data  <= period_data;
        @(posedge clk);
        cfg_index <= atrw_pkg::CFG_MINIMUM_BARS;
        cfg_data  <= min_data;
        @(posedge clk);
        cfg_write <= 1'b0;
        board.set_window(period_data, min_data);
    endtask

    task automatic random_phase(input logic [CB-1:0] period_data);
        logic [CB-1:0] min_data;
        int            count;

        finish_phase();
        case ($urandom_range(0, 3))
            0:       min_data = 12'd0;
            1:       min_data = 12'd1;
            2:       min_data = 12'd2;
            default: min_data = CB'($urandom_range(3, 80));
        endcase
        set_window(period_data, min_data);
        sender_gaps = ($urandom_range(0, 3) != 0);
        walk_price  = $urandom_range(0, 1) ? $urandom : $urandom_range(1000, 100000);
        count = $urandom_range(40, 70);
        for (int i = 0; i < count; i++)
            send_bar(random_bar(i == 0 ? ($urandom_range(0, 3) != 0)
                                       : ($urandom_range(0, 49) == 0)));
    endtask

    // random upper bits on the period write; only the low 7 bits count
    function automatic logic [CB-1:0] period_word(int value);
        logic [CB-1:0] w;

        w = CB'($urandom);
        w[atrw_pkg::PERIOD_BITS-1:0] = atrw_pkg::PERIOD_BITS'(value);
        return w;
    endfunction

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset window settings; first bar after reset without a start flag
        send_bar(make_bar(32'd100, 32'd50, 32'd70, 1'b0));
        send_bar(make_bar('1, '0, '1, 1'b0));
        send_bar(make_bar('0, '1, '0, 1'b0));
        send_bar(make_bar(32'd10, 32'd5, 32'd7, 1'b0));
        send_bar(make_bar(32'd3, 32'd1, 32'd2, 1'b0));
        send_bar(make_bar(32'd50, 32'd40, 32'd45, 1'b0));
        send_bar(make_bar('1, '1, 32'h8000_0000, 1'b0));
        send_bar(make_bar('0, '0, '0, 1'b0));
        for (int i = 0; i < 9; i++)
            send_bar(random_bar(1'b0));
        send_bar(make_bar(32'd20, 32'd10, 32'd15, 1'b1));

        // zero period
        finish_phase();
        set_window(12'd0, 12'd0);
        send_bar(random_bar(1'b0));
        send_bar(random_bar(1'b0));

        // period above the ring size, no minimum
        finish_phase();
        set_window(12'hFFF, 12'd0);
        send_bar(make_bar(32'd500, 32'd400, 32'd450, 1'b1));
        send_bar(make_bar('1, '0, '0, 1'b0));
        send_bar(make_bar(32'd7, 32'd9, 32'd8, 1'b0));
        send_bar(random_bar(1'b0));

        random_phase(period_word(64));
        random_phase(period_word(1));
        random_phase(period_word(0));
        random_phase(period_word($urandom_range(65, 127)));
        random_phase(period_word($urandom_range(1, 64)));
        random_phase(period_word($urandom_range(1, 16)));

        // one long series, valid only past a large minimum bar count
        finish_phase();
        set_window(period_word(5), 12'd100);
        sender_gaps = 1'b0;
        for (int i = 0; i < 120; i++)
            send_bar(random_bar(i == 0));

        random_phase(period_word(64));
        for (int p = 0; p < 5; p++)
            random_phase(period_word($urandom_range(0, 3) == 0 ? $urandom_range(0, 127)
                                                               : $urandom_range(1, 64)));

        finish_phase();
        repeat (120) @(posedge clk);
        if (board.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/atrw_pkg.sv
sv/average_true_range_window.sv
tb/testbench.sv
